// ===== hw/rtl/wfe_pkg.sv =====
`default_nettype none

package wfe_pkg;

    // Command codes
    typedef enum logic
    {
        CMD_START,
        CMD_PAYLOAD
    } cmd_t;

    localparam int KEY_BYTES   = 4;
    localparam int IDX_W       = 4;

    localparam logic [6:0]  LEN_CODE_16     = 7'h7E;
    localparam logic [6:0]  LEN_CODE_64     = 7'h7F;
    localparam logic [31:0] LEN_SHORT_LIMIT = 32'd126;
    localparam logic [31:0] LEN_MID_LIMIT   = 32'd65536;

    // One input transfer
    typedef struct packed
    {
        cmd_t        command;
        logic        fin_bit;
        logic [3:0]  frame_opcode;
        logic        mask_enable;
        logic [31:0] payload_length;
        logic [31:0] masking_key;
        logic [7:0]  payload_byte;
    } in_item_t;

    // One result transfer
    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
        logic       protocol_error;
    } out_item_t;

    // Work handed from the front to the back
    typedef struct packed
    {
        logic        is_hdr;
        logic        fin_bit;
        logic [3:0]  frame_opcode;
        logic        mask_enable;
        logic [31:0] len;
        logic [31:0] key;
        logic [7:0]  data;
        logic        frame_end;
        logic        err;
    } job_t;

    // Key byte by phase, wire order from the top byte down
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] phase);
        logic [7:0] b;
        unique case (phase)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

    // Extended length byte count: 0, 2 or 8
    function automatic logic [IDX_W-1:0] ext_count(input logic [31:0] len);
        logic [IDX_W-1:0] n;
        if (len < LEN_SHORT_LIMIT)
            n = IDX_W'(0);
        else if (len < LEN_MID_LIMIT)
            n = IDX_W'(2);
        else
            n = IDX_W'(8);
        return n;
    endfunction

    // Total header bytes for a start job
    function automatic logic [IDX_W-1:0] hdr_count(input job_t job);
        logic [IDX_W-1:0] n;
        n = IDX_W'(2) + ext_count(job.len) + (job.mask_enable ? IDX_W'(KEY_BYTES) : IDX_W'(0));
        return n;
    endfunction

    // Header byte at a given position
    function automatic logic [7:0] hdr_byte(input job_t job, input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] ext_n;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic [6:0]       code;
        logic [7:0]       b;
        ext_n = ext_count(job.len);
        j     = idx - IDX_W'(2);
        k     = idx - IDX_W'(2) - ext_n;
        if (ext_n == IDX_W'(0))
            code = job.len[6:0];
        else if (ext_n == IDX_W'(2))
            code = LEN_CODE_16;
        else
            code = LEN_CODE_64;
        if (idx == IDX_W'(0))
            b = {job.fin_bit, 3'b000, job.frame_opcode};
        else if (idx == IDX_W'(1))
            b = {job.mask_enable, code};
        else if (idx < IDX_W'(2) + ext_n)
        begin
            if (ext_n == IDX_W'(2))
                b = (j == IDX_W'(0)) ? job.len[15:8] : job.len[7:0];
            else
            begin
                unique case (j)
                    IDX_W'(4): b = job.len[31:24];
                    IDX_W'(5): b = job.len[23:16];
                    IDX_W'(6): b = job.len[15:8];
                    IDX_W'(7): b = job.len[7:0];
                    default:   b = 8'h00;
                endcase
            end
        end
        else
            b = key_byte(job.key, k[1:0]);
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wfe_front.sv =====
`default_nettype none

module wfe_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic             full,
    input  wire wfe_pkg::in_item_t item,
    output logic                  job_push,
    output wfe_pkg::job_t         job
);
    import wfe_pkg::*;

    logic [31:0] rem_reg,     rem_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [31:0] key_reg,     key_next;
    logic        mask_on_reg, mask_on_next;
    logic        take;

    assign take     = push && !full;
    assign job_push = take;

    // Classify the transfer and track frame state
    always_comb
    begin
        rem_next     = rem_reg;
        phase_next   = phase_reg;
        key_next     = key_reg;
        mask_on_next = mask_on_reg;

        job              = '0;
        job.fin_bit      = item.fin_bit;
        job.frame_opcode = item.frame_opcode;
        job.mask_enable  = item.mask_enable;
        job.len          = item.payload_length;
        job.key          = item.masking_key;

        if (item.command == CMD_START)
        begin
            job.is_hdr = 1'b1;
            if (take)
            begin
                rem_next     = item.payload_length;
                phase_next   = 2'd0;
                key_next     = item.masking_key;
                mask_on_next = item.mask_enable;
            end
        end
        else if (rem_reg == 32'd0)
        begin
            // stray payload byte: flagged and dropped
            job.err = 1'b1;
        end
        else
        begin
            job.data      = mask_on_reg ? (item.payload_byte ^ key_byte(key_reg, phase_reg))
                                        : item.payload_byte;
            job.frame_end = (rem_reg == 32'd1);
            if (take)
            begin
                rem_next   = rem_reg - 32'd1;
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            phase_reg   <= '0;
            key_reg     <= '0;
            mask_on_reg <= 1'b0;
        end
        else
        begin
            rem_reg     <= rem_next;
            phase_reg   <= phase_next;
            key_reg     <= key_next;
            mask_on_reg <= mask_on_next;
        end
    end

`ifndef SYNTHESIS
    a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.command == CMD_PAYLOAD && rem_reg == 32'd0) |=> $stable(rem_reg))
        else $error("stray payload byte changed the remaining count");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/wfe_job_fifo.sv =====
`default_nettype none

module wfe_job_fifo
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire wfe_pkg::job_t wr_job,
    output logic               full,
    input  wire logic          rd_en,
    output logic               empty,
    output wfe_pkg::job_t      head
);
    import wfe_pkg::*;

    job_t       jobs_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = jobs_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            jobs_reg[wr_ptr_reg] <= wr_job;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wfe_back.sv =====
`default_nettype none

module wfe_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_empty,
    input  wire wfe_pkg::job_t job_head,
    output logic               job_pop,
    input  wire logic          pop,
    output logic               empty,
    output wfe_pkg::out_item_t result
);
    import wfe_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] hdr_n;
    logic             last_hdr;
    logic             emit;
    logic             take_out;
    out_item_t        emit_item;

    out_item_t        outq_reg [2];
    logic             out_wr_reg;
    logic             out_rd_reg;
    logic [1:0]       out_count_reg, out_count_next;

    // Header expansion, one byte per cycle while the result queue has room
    assign hdr_n    = hdr_count(job_head);
    assign last_hdr = (idx_reg == hdr_n - IDX_W'(1));
    assign emit     = !job_empty && (out_count_reg != 2'd2);
    assign job_pop  = emit && (!job_head.is_hdr || last_hdr);

    always_comb
    begin
        if (job_head.is_hdr)
        begin
            emit_item.out_byte       = hdr_byte(job_head, idx_reg);
            emit_item.last_of_run    = last_hdr;
            emit_item.frame_end      = last_hdr && (job_head.len == 32'd0);
            emit_item.protocol_error = 1'b0;
        end
        else
        begin
            emit_item.out_byte       = job_head.data;
            emit_item.last_of_run    = 1'b1;
            emit_item.frame_end      = job_head.frame_end;
            emit_item.protocol_error = job_head.err;
        end

        idx_next = idx_reg;
        if (emit && job_head.is_hdr)
            idx_next = last_hdr ? IDX_W'(0) : idx_reg + IDX_W'(1);
    end

    // Result queue towards the consumer
    assign take_out = pop && (out_count_reg != 2'd0);
    assign empty    = (out_count_reg == 2'd0);
    assign result   = outq_reg[out_rd_reg];

    always_comb
    begin
        out_count_next = out_count_reg + {1'b0, emit} - {1'b0, take_out};
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            outq_reg[out_wr_reg] <= emit_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_wr_reg    <= 1'b0;
            out_rd_reg    <= 1'b0;
            out_count_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (emit)
                out_wr_reg <= ~out_wr_reg;
            if (take_out)
                out_rd_reg <= ~out_rd_reg;
            out_count_reg <= out_count_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_on_header: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != IDX_W'(0)) |-> (!job_empty && job_head.is_hdr))
        else $error("header position set with no header job at the head");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!job_empty && job_head.is_hdr) |-> (idx_reg < hdr_n))
        else $error("header position beyond header length");

    a_outq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg != 2'd3)
        else $error("result queue overfilled");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_encoder.sv =====
// Channel   Handshake          Payload
// -------   ----------------   ---------------------------
// input     push / full        item   (wfe_pkg::in_item_t)
// result    pop / empty        result (wfe_pkg::out_item_t)
//
// A payload command yields one result; the result path sustains one per cycle while results are popped.
// A start command occupies the header expander for 2 to 14 header bytes, one byte a cycle when not stalled.
// The first result of a transfer is registered in the job queue, then in the result queue, before it appears.
// A two-entry job queue lets input be taken while the expander or the result side stalls.
// Reset empties both queues and clears the frame state.
`default_nettype none

module websocket_frame_encoder
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire wfe_pkg::in_item_t item,
    input  wire logic              pop,
    output logic                   empty,
    output wfe_pkg::out_item_t     result
);
    import wfe_pkg::*;

    logic job_push;
    logic job_pop;
    logic job_empty;
    job_t job_in;
    job_t job_head;

    wfe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_push (job_push),
        .job      (job_in)
    );

    wfe_job_fifo u_job_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .full   (full),
        .rd_en  (job_pop),
        .empty  (job_empty),
        .head   (job_head)
    );

    wfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire
